### hdl/tmcr_pkg.sv
// Shared types and constants of the text-mode character raster generator.
`default_nettype none

package tmcr_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COLUMNS_PER_ROW = 2'd0,
        CFG_TEXT_ROWS       = 2'd1,
        CFG_LINES_PER_ROW   = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        REQ_VIDEO_WR  = 2'd0,
        REQ_GLYPH_WR  = 2'd1,
        REQ_GENERATE  = 2'd2
    } t_req_code;

    localparam logic [7:0] COLS_RESET  = 8'd80;
    localparam logic [5:0] ROWS_RESET  = 6'd24;
    localparam logic [4:0] LINES_RESET = 5'd11;
    localparam logic [7:0] COLS_MAX    = 8'd128;
    localparam logic [5:0] ROWS_MAX    = 6'd32;
    localparam logic [4:0] LINES_MAX   = 5'd16;

    localparam int CODE_INVERT_BIT = 7;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  req_type;
        logic [10:0] addr;
        logic [7:0]  data;
    } t_req_item;

    typedef struct packed {
        logic [7:0] pixels;
        logic [6:0] cell_column;
        logic [8:0] raster_line;
        logic       frame_end;
    } t_res_item;

    typedef struct packed {
        logic [6:0] cell_column;
        logic [8:0] raster_line;
        logic       frame_end;
        logic [3:0] line_in_row;
    } t_cell_info;

endpackage

`default_nettype wire

### hdl/tmcr_chan_if.sv
// Valid/ready channel carrying one payload item per transfer.
`default_nettype none

interface tmcr_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### hdl/tmcr_ram.sv
// Byte-wide memory with one write port and one registered read port.
`default_nettype none

module tmcr_ram #(
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [7:0]               i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [7:0]               o_rdata
);
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

### hdl/tmcr_scan.sv
// Configuration registers and the column, line and row counters of the raster scan.
`default_nettype none

module tmcr_scan #(
    parameter int VIDEO_AW = 11
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [tmcr_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [tmcr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                               i_advance,
    output tmcr_pkg::t_cell_info                    o_info,
    output logic      [VIDEO_AW-1:0]                o_vaddr
);
    import tmcr_pkg::*;

    logic [7:0]          r_cols_cfg;
    logic [5:0]          r_rows_cfg;
    logic [4:0]          r_lines_cfg;
    logic [6:0]          r_col, n_col;
    logic [3:0]          r_line, n_line;
    logic [4:0]          r_row, n_row;
    logic [VIDEO_AW-1:0] r_base, n_base;
    logic [8:0]          r_raster, n_raster;
    logic [7:0]          cols;
    logic [5:0]          rows;
    logic [4:0]          lines;
    logic                last_col, last_line, last_row;
    logic [VIDEO_AW:0]   vsum, base_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_cfg  <= COLS_RESET;
            r_rows_cfg  <= ROWS_RESET;
            r_lines_cfg <= LINES_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_COLUMNS_PER_ROW: r_cols_cfg  <= i_cfg_data;
                CFG_TEXT_ROWS:       r_rows_cfg  <= i_cfg_data[5:0];
                CFG_LINES_PER_ROW:   r_lines_cfg <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cols  = (r_cols_cfg == '0) ? 8'd1 : ((r_cols_cfg > COLS_MAX) ? COLS_MAX : r_cols_cfg);
        rows  = (r_rows_cfg == '0) ? 6'd1 : ((r_rows_cfg > ROWS_MAX) ? ROWS_MAX : r_rows_cfg);
        lines = (r_lines_cfg == '0) ? 5'd1
              : ((r_lines_cfg > LINES_MAX) ? LINES_MAX : r_lines_cfg);

        last_col  = ({1'b0, r_col} + 8'd1) >= cols;
        last_line = ({1'b0, r_line} + 5'd1) >= lines;
        last_row  = ({1'b0, r_row} + 6'd1) >= rows;

        vsum     = {1'b0, r_base} + (VIDEO_AW+1)'(r_col);
        base_sum = {1'b0, r_base} + (VIDEO_AW+1)'(cols);

        n_col    = r_col;
        n_line   = r_line;
        n_row    = r_row;
        n_base   = r_base;
        n_raster = r_raster;
        if (!last_col) begin
            n_col = r_col + 7'd1;
        end else begin
            n_col = '0;
            if (!last_line) begin
                n_line   = r_line + 4'd1;
                n_raster = r_raster + 9'd1;
            end else begin
                n_line = '0;
                if (!last_row) begin
                    n_row    = r_row + 5'd1;
                    n_base   = base_sum[VIDEO_AW-1:0];
                    n_raster = r_raster + 9'd1;
                end else begin
                    n_row    = '0;
                    n_base   = '0;
                    n_raster = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_line   <= '0;
            r_row    <= '0;
            r_base   <= '0;
            r_raster <= '0;
        end else if (i_advance) begin
            r_col    <= n_col;
            r_line   <= n_line;
            r_row    <= n_row;
            r_base   <= n_base;
            r_raster <= n_raster;
        end
    end

    assign o_info.cell_column = r_col;
    assign o_info.raster_line = r_raster;
    assign o_info.frame_end   = last_col && last_line && last_row;
    assign o_info.line_in_row = r_line;
    assign o_vaddr            = vsum[VIDEO_AW-1:0];

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_info.frame_end)
        |=> (r_col == '0 && r_line == '0 && r_row == '0 && r_base == '0 && r_raster == '0))
        else $error("counters did not wrap after the last cell of the frame");
endmodule

`default_nettype wire

### hdl/tmcr_out_fifo.sv
// Small result queue that decouples the pipeline from the output handshake.
`default_nettype none

module tmcr_out_fifo (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_push,
    input  tmcr_pkg::t_res_item                   i_data,
    output logic                                  o_valid,
    output tmcr_pkg::t_res_item                   o_data,
    input  wire logic                             i_ready,
    output logic      [tmcr_pkg::FIFO_CW-1:0]     o_count
);
    import tmcr_pkg::*;

    t_res_item          r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr, r_rptr;
    logic [FIFO_CW-1:0] r_count;
    logic               pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign pop     = o_valid && i_ready;
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + FIFO_CW'(i_push) - FIFO_CW'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == FIFO_CW'(FIFO_DEPTH) && i_push) |-> pop)
        else $error("result queue overflow");
endmodule

`default_nettype wire

### hdl/text_mode_character_raster_top.sv
// Top level: request decode, video clear sweep and the two-stage memory read pipeline.
// An accepted generate transfer passes the video read, glyph read and result queue to o_res.
// One request per cycle is accepted while i_req.ready is high; the two reads are pipelined.
// Up to four results queue, so o_res stalls cost no throughput until inflight reaches four.
// After reset a sweep clears every video store address, holding i_req.ready low.
// Reset also restores the registers to 80 columns, 24 rows and 11 lines per row.
`default_nettype none

module text_mode_character_raster_top #(
    parameter int VIDEO_DEPTH = 2048,
    parameter int GLYPH_DEPTH = 2048
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [tmcr_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [tmcr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    tmcr_chan_if.sink                               i_req,
    tmcr_chan_if.source                             o_res
);
    import tmcr_pkg::*;

    localparam int VIDEO_AW = $clog2(VIDEO_DEPTH);
    localparam int GLYPH_AW = $clog2(GLYPH_DEPTH);

    t_req_item           req;
    logic                accept, gen;
    logic                r_clr_busy;
    logic [VIDEO_AW-1:0] r_clr_addr;
    logic                vid_we;
    logic [VIDEO_AW-1:0] vid_waddr, vid_raddr;
    logic [7:0]          vid_wdata, vid_rdata;
    logic                glyph_we;
    logic [GLYPH_AW-1:0] glyph_raddr;
    logic [7:0]          glyph_rdata;
    t_cell_info          scan_info;
    logic                r_s1_valid, r_s2_valid;
    t_cell_info          r_s1_info, r_s2_info;
    logic                r_s2_invert;
    t_res_item           result;
    logic                fifo_valid;
    t_res_item           fifo_data;
    logic [FIFO_CW-1:0]  fifo_count;
    logic [FIFO_CW-1:0]  inflight;

    assign req    = i_req.payload;
    assign accept = i_req.valid && i_req.ready;
    assign gen    = accept && (req.req_type == REQ_GENERATE);

    assign inflight    = fifo_count + FIFO_CW'(r_s1_valid) + FIFO_CW'(r_s2_valid);
    assign i_req.ready = !r_clr_busy && (inflight < FIFO_CW'(FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == VIDEO_AW'(VIDEO_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign vid_we    = r_clr_busy || (accept && req.req_type == REQ_VIDEO_WR);
    assign vid_waddr = r_clr_busy ? r_clr_addr : VIDEO_AW'(req.addr);
    assign vid_wdata = r_clr_busy ? 8'd0 : req.data;
    assign glyph_we  = accept && (req.req_type == REQ_GLYPH_WR);

    tmcr_scan #(
        .VIDEO_AW (VIDEO_AW)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_advance   (gen),
        .o_info      (scan_info),
        .o_vaddr     (vid_raddr)
    );

    tmcr_ram #(
        .DEPTH (VIDEO_DEPTH)
    ) u_video (
        .i_clk   (i_clk),
        .i_we    (vid_we),
        .i_waddr (vid_waddr),
        .i_wdata (vid_wdata),
        .i_raddr (vid_raddr),
        .o_rdata (vid_rdata)
    );

    assign glyph_raddr = GLYPH_AW'({vid_rdata[6:0], r_s1_info.line_in_row});

    tmcr_ram #(
        .DEPTH (GLYPH_DEPTH)
    ) u_glyph (
        .i_clk   (i_clk),
        .i_we    (glyph_we),
        .i_waddr (GLYPH_AW'(req.addr)),
        .i_wdata (req.data),
        .i_raddr (glyph_raddr),
        .o_rdata (glyph_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= gen;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_info   <= scan_info;
        r_s2_info   <= r_s1_info;
        r_s2_invert <= !vid_rdata[CODE_INVERT_BIT];
    end

    assign result.pixels      = glyph_rdata ^ {8{r_s2_invert}};
    assign result.cell_column = r_s2_info.cell_column;
    assign result.raster_line = r_s2_info.raster_line;
    assign result.frame_end   = r_s2_info.frame_end;

    tmcr_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s2_valid),
        .i_data  (result),
        .o_valid (fifo_valid),
        .o_data  (fifo_data),
        .i_ready (o_res.ready),
        .o_count (fifo_count)
    );

    assign o_res.valid   = fifo_valid;
    assign o_res.payload = fifo_data;

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !i_req.ready)
        else $error("request accepted during the video clear sweep");

    a_pipe_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |=> r_s2_valid)
        else $error("generate request lost between the video and glyph reads");

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        gen |-> (inflight < FIFO_CW'(FIFO_DEPTH)))
        else $error("generate request accepted without room in the result queue");
endmodule

`default_nettype wire

### bench/tb_top.sv
// Self-checking testbench of the text-mode character raster generator with a cell row predictor.
`timescale 1ns / 1ps

module tb_top;
    import tmcr_pkg::*;

    localparam int          VIDEO_DEPTH   = 2048;
    localparam int          GLYPH_DEPTH   = 2048;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          DRAIN_CYCLES  = 8;
    localparam int          HOLD_CYCLES   = 300;
    localparam logic [1:0]  REQ_UNUSED    = 2'd3;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    tmcr_chan_if #(.t_payload(t_req_item)) req_if ();
    tmcr_chan_if #(.t_payload(t_res_item)) res_if ();

    text_mode_character_raster_top #(
        .VIDEO_DEPTH (VIDEO_DEPTH),
        .GLYPH_DEPTH (GLYPH_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_req       (req_if),
        .o_res       (res_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_req_item  req_backlog [$];
    t_res_item  cell_rows_due [$];
    logic [6:0] loaded_codes [$];
    bit         code_loaded [128];

    logic [7:0] video_mirror [VIDEO_DEPTH];
    logic [7:0] glyph_mirror [GLYPH_DEPTH];
    logic [7:0] mirror_cols  = COLS_RESET;
    logic [5:0] mirror_rows  = ROWS_RESET;
    logic [4:0] mirror_lines = LINES_RESET;
    int column_at  = 0;
    int line_at    = 0;
    int row_at     = 0;
    int row_base   = 0;
    int raster_at  = 0;

    int  sender_idle_pct = 0;
    int  recv_idle_pct   = 0;
    bit  stall_armed     = 1'b0;
    logic res_hold       = 1'b0;
    int  mismatch_count  = 0;
    int  cycle_count     = 0;
    t_res_item got_row;
    t_res_item due_row;

    task automatic raster_step(input t_req_item req);
        int cols;
        int rows;
        int lines;
        logic [7:0] code;
        logic [7:0] glyph;
        bit last_col;
        bit last_line;
        bit last_row;
        t_res_item row_out;
        if (req.req_type == REQ_VIDEO_WR) begin
            video_mirror[req.addr] = req.data;
        end else if (req.req_type == REQ_GLYPH_WR) begin
            glyph_mirror[req.addr] = req.data;
        end else if (req.req_type == REQ_GENERATE) begin
            cols  = (mirror_cols == 0) ? 1 : (mirror_cols > COLS_MAX) ? COLS_MAX : mirror_cols;
            rows  = (mirror_rows == 0) ? 1 : (mirror_rows > ROWS_MAX) ? ROWS_MAX : mirror_rows;
            lines = (mirror_lines == 0) ? 1 :
                    (mirror_lines > LINES_MAX) ? LINES_MAX : mirror_lines;
            code  = video_mirror[(row_base + column_at) % VIDEO_DEPTH];
            glyph = glyph_mirror[((int'(code[6:0]) << 4) | (line_at & 15)) % GLYPH_DEPTH];
            last_col  = (column_at + 1 >= cols);
            last_line = (line_at + 1 >= lines);
            last_row  = (row_at + 1 >= rows);
            row_out.pixels      = code[CODE_INVERT_BIT] ? glyph : ~glyph;
            row_out.cell_column = 7'(column_at);
            row_out.raster_line = 9'(raster_at);
            row_out.frame_end   = last_col && last_line && last_row;
            cell_rows_due.push_back(row_out);
            if (!last_col) begin
                column_at = (column_at + 1) & 127;
            end else begin
                column_at = 0;
                if (!last_line) begin
                    line_at   = (line_at + 1) & 15;
                    raster_at = (raster_at + 1) & 511;
                end else begin
                    line_at = 0;
                    if (!last_row) begin
                        row_at    = (row_at + 1) & 31;
                        row_base  = (row_base + cols) % VIDEO_DEPTH;
                        raster_at = (raster_at + 1) & 511;
                    end else begin
                        row_at    = 0;
                        row_base  = 0;
                        raster_at = 0;
                    end
                end
            end
        end
    endtask

    task automatic queue_req(input logic [1:0] kind, input logic [10:0] addr,
                             input logic [7:0] data);
        t_req_item req;
        req.req_type = kind;
        req.addr     = addr;
        req.data     = data;
        req_backlog.push_back(req);
    endtask

    // All sixteen lines of a glyph are written before any video write may use its code.
    task automatic queue_glyph_code(input logic [6:0] code);
        int line;
        for (line = 0; line < 16; line++) begin
            queue_req(REQ_GLYPH_WR, {code, 4'(line)}, 8'($urandom_range(255)));
        end
        if (!code_loaded[code]) begin
            code_loaded[code] = 1'b1;
            loaded_codes.push_back(code);
        end
    endtask

    task automatic queue_mix(input int count, input int gen_pct);
        int n;
        int pick;
        logic [10:0] addr;
        for (n = 0; n < count; n++) begin
            addr = 11'($urandom_range(2047));
            if ($urandom_range(99) < gen_pct) begin
                queue_req(REQ_GENERATE, addr, 8'($urandom_range(255)));
            end else begin
                pick = $urandom_range(99);
                if (pick < 55) begin
                    if ($urandom_range(1) == 0) begin
                        addr = 11'($urandom_range(255));
                    end
                    queue_req(REQ_VIDEO_WR, addr, {($urandom_range(1) == 1),
                              loaded_codes[$urandom_range(loaded_codes.size() - 1)]});
                end else if (pick < 80) begin
                    queue_req(REQ_GLYPH_WR, addr, 8'($urandom_range(255)));
                end else if (pick < 90) begin
                    queue_req(REQ_UNUSED, addr, 8'($urandom_range(255)));
                end else begin
                    queue_glyph_code(7'($urandom_range(127)));
                end
            end
        end
    endtask

    task automatic settle();
        while (req_backlog.size() != 0 || req_if.valid || cell_rows_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_index idx, input logic [7:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_COLUMNS_PER_ROW: mirror_cols  = value;
            CFG_TEXT_ROWS:       mirror_rows  = value[5:0];
            CFG_LINES_PER_ROW:   mirror_lines = value[4:0];
            default: ;
        endcase
    endtask

    task automatic run_phase(input logic [7:0] cols, input logic [7:0] rows,
                             input logic [7:0] lines, input int items, input int gen_pct,
                             input int send_pct, input int recv_pct, input bit hold);
        sender_idle_pct = send_pct;
        recv_idle_pct   = recv_pct;
        write_register(CFG_COLUMNS_PER_ROW, cols);
        write_register(CFG_TEXT_ROWS, rows);
        write_register(CFG_LINES_PER_ROW, lines);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        queue_mix(items, gen_pct);
        if (hold) begin
            stall_armed = 1'b1;
        end
        settle();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                raster_step(req_if.payload);
            end
            if (!req_if.valid || req_if.ready) begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    req_if.payload <= req_backlog.pop_front();
                    req_if.valid   <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got_row = res_if.payload;
                if (cell_rows_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected cell row: pixels %h column %0d line %0d end %0b",
                                 got_row.pixels, got_row.cell_column, got_row.raster_line,
                                 got_row.frame_end);
                    end
                end else begin
                    due_row = cell_rows_due.pop_front();
                    if (got_row.pixels !== due_row.pixels ||
                        got_row.cell_column !== due_row.cell_column ||
                        got_row.raster_line !== due_row.raster_line ||
                        got_row.frame_end !== due_row.frame_end) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("cell row mismatch: expected %h/%0d/%0d/%0b, got %h/%0d/%0d/%0b",
                                     due_row.pixels, due_row.cell_column, due_row.raster_line,
                                     due_row.frame_end, got_row.pixels, got_row.cell_column,
                                     got_row.raster_line, got_row.frame_end);
                        end
                    end
                end
            end
            res_if.ready <= !res_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // The output is held off for a long stretch so that the result queue fills and stalls requests.
    initial begin
        wait (stall_armed);
        @(posedge i_clk);
        res_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        res_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int i;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        res_if.ready   = 1'b0;
        for (i = 0; i < VIDEO_DEPTH; i++) begin
            video_mirror[i] = 8'h00;
        end
        for (i = 0; i < GLYPH_DEPTH; i++) begin
            glyph_mirror[i] = 8'h00;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct = 37;
        recv_idle_pct   = 58;
        queue_glyph_code(7'h00);
        queue_req(REQ_GLYPH_WR, 11'd0, 8'h00);
        queue_req(REQ_GLYPH_WR, 11'd2047, 8'hff);
        queue_req(REQ_GENERATE, 11'd0, 8'h00);
        queue_req(REQ_VIDEO_WR, 11'd2047, 8'h80);
        queue_req(REQ_VIDEO_WR, 11'd2, 8'h80);
        queue_req(REQ_UNUSED, 11'd2047, 8'hff);
        queue_req(REQ_GENERATE, 11'd2047, 8'hff);
        queue_req(REQ_GENERATE, 11'd1024, 8'h55);
        queue_req(REQ_GENERATE, 11'd0, 8'h00);
        queue_glyph_code(7'h7f);
        queue_mix(80, 50);
        settle();

        run_phase(8'd1, 8'd1, 8'd1, 60, 50, 37, 58, 1'b0);
        run_phase(8'd0, 8'd0, 8'd0, 50, 50, 37, 58, 1'b0);
        run_phase(8'd3, 8'd2, 8'd2, 80, 60, 37, 58, 1'b0);
        run_phase(8'd255, 8'd63, 8'd31, 80, 50, 58, 37, 1'b0);
        run_phase(8'd5, 8'd3, 8'd16, 100, 60, 58, 37, 1'b0);
        run_phase(COLS_MAX, 8'(ROWS_MAX), 8'd1, 150, 92, 58, 37, 1'b1);
        for (i = 0; i < 3; i++) begin
            run_phase(8'($urandom_range(1, 12)), 8'($urandom_range(1, 4)),
                      8'($urandom_range(1, 6)), 40, 60, 0, 0, 1'b0);
        end

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### sim.f
hdl/tmcr_pkg.sv
hdl/tmcr_chan_if.sv
hdl/tmcr_ram.sv
hdl/tmcr_scan.sv
hdl/tmcr_out_fifo.sv
hdl/text_mode_character_raster_top.sv
bench/tb_top.sv
